/* hdl/aie_pkg.sv */
package aie_pkg;

    localparam int unsigned HDR_BYTES = 42;
    localparam int unsigned HDR_AW    = 6;

    localparam logic [HDR_AW-1:0] HDR_FULL   = HDR_AW'(HDR_BYTES);
    localparam logic [HDR_AW-1:0] IP_FIRST   = 6'd14;
    localparam logic [HDR_AW-1:0] IP_LAST    = 6'd33;
    localparam logic [HDR_AW-1:0] ICMP_LAST  = 6'd41;
    localparam logic [HDR_AW-1:0] TYPE_HI    = 6'd12;
    localparam logic [HDR_AW-1:0] TYPE_LO    = 6'd13;

    localparam logic [6:0] ARP_LAST_BYTE  = 7'd41;
    localparam logic [6:0] ICMP_LAST_BYTE = 7'd97;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;

    // where one reply byte comes from
    localparam logic [2:0] SRC_RAM  = 3'd0;
    localparam logic [2:0] SRC_ADJ  = 3'd1;
    localparam logic [2:0] SRC_CON  = 3'd2;
    localparam logic [2:0] SRC_IPH  = 3'd3;
    localparam logic [2:0] SRC_IPL  = 3'd4;
    localparam logic [2:0] SRC_ICH  = 3'd5;
    localparam logic [2:0] SRC_ICL  = 3'd6;

    typedef struct packed {
        logic [2:0]        kind;
        logic [HDR_AW-1:0] addr;
        logic [7:0]        cval;
    } t_src;

    typedef struct packed {
        logic        add;
        logic        clr;
        logic [15:0] value;
    } t_csum_ctl;

    function automatic t_src src_map(input logic is_arp, input logic [6:0] j);
        t_src s;
        s = '{kind: SRC_CON, addr: '0, cval: 8'h00};
        if (is_arp) begin
            unique case (j) inside
                [7'd0:7'd5]:   begin s.kind = SRC_RAM; s.addr = 6'(j + 7'd22); end
                [7'd6:7'd10]:  begin s.kind = SRC_RAM; s.addr = 6'(j + 7'd16); end
                7'd11, 7'd27:  begin s.kind = SRC_ADJ; s.addr = 6'd27; end
                7'd12:         s.cval = 8'h08;
                7'd13:         s.cval = 8'h06;
                7'd14:         s.cval = 8'h00;
                7'd15:         s.cval = 8'h01;
                7'd16:         s.cval = 8'h08;
                7'd17:         s.cval = 8'h00;
                7'd18:         s.cval = 8'h06;
                7'd19:         s.cval = 8'h04;
                7'd20:         s.cval = 8'h00;
                7'd21:         s.cval = 8'h02;
                [7'd22:7'd26]: begin s.kind = SRC_RAM; s.addr = 6'(j); end
                [7'd28:7'd31]: begin s.kind = SRC_RAM; s.addr = 6'(j + 7'd10); end
                [7'd32:7'd41]: begin s.kind = SRC_RAM; s.addr = 6'(j - 7'd10); end
                default:       s.cval = 8'h00;
            endcase
        end else begin
            unique case (j) inside
                [7'd0:7'd5]:   begin s.kind = SRC_RAM; s.addr = 6'(j + 7'd6); end
                [7'd6:7'd11]:  begin s.kind = SRC_RAM; s.addr = 6'(j - 7'd6); end
                7'd12:         s.cval = 8'h08;
                7'd13:         s.cval = 8'h00;
                [7'd14:7'd23]: begin s.kind = SRC_RAM; s.addr = 6'(j); end
                7'd24:         s.kind = SRC_IPH;
                7'd25:         s.kind = SRC_IPL;
                [7'd26:7'd29]: begin s.kind = SRC_RAM; s.addr = 6'(j + 7'd4); end
                [7'd30:7'd33]: begin s.kind = SRC_RAM; s.addr = 6'(j - 7'd4); end
                7'd36:         s.kind = SRC_ICH;
                7'd37:         s.kind = SRC_ICL;
                [7'd38:7'd41]: begin s.kind = SRC_RAM; s.addr = 6'(j); end
                default:       s.cval = 8'h00;
            endcase
        end
        return s;
    endfunction

endpackage

/* hdl/aie_ram.sv */
module aie_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/aie_csum.sv */
module aie_csum
    import aie_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_csum_ctl i_ctl,
    output logic [15:0] o_sum
);

    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic [16:0] raw;
    logic [15:0] folded;

    // ones-complement add with end-around carry
    always_comb begin
        raw    = {1'b0, r_acc} + {1'b0, i_ctl.value};
        folded = raw[15:0] + {15'd0, raw[16]};
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.add) begin
            n_acc = folded;
        end
        if (i_ctl.clr) begin
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_sum = folded;

endmodule

/* hdl/arp_icmp_echo_responder.sv */
// Channel  | Signals                                     | Direction
// ---------+---------------------------------------------+-----------
// frame in | i_in_valid, o_in_stall, i_data_byte,        | in
//          | i_frame_end                                 |
// reply    | o_out_valid, i_out_stall, o_reply_word,     | out
//          | o_reply_end                                 |
// config   | i_cfg_we, i_cfg_wdata (mac_offset)          | in
//
// Frame bytes are taken one per cycle when not stalled; the first 42 go into
// a byte-wide RAM. After a frame's last beat an IPv4 frame sums its header
// and ICMP words through the one checksum adder, reading one byte per cycle.
// Replies are then built from the same RAM port, a read and a write state
// per byte (42 bytes for ARP, 98 for ICMP), holding while the output stalls.
// The input is stalled while a reply is being summed or built.
// Synchronous active-low reset; mac_offset resets to 2.
module arp_icmp_echo_responder
    import aie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_reply_word,
    output logic        o_reply_end,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam logic [1:0] ST_CAP     = 2'd0;
    localparam logic [1:0] ST_SUM     = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_WR = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [HDR_AW-1:0] r_byte_count, n_byte_count;
    logic [15:0]       r_etype, n_etype;
    logic [7:0]        r_mac_offset;
    logic              r_is_arp, n_is_arp;
    logic [HDR_AW-1:0] r_addr, n_addr;
    logic [HDR_AW-1:0] r_prev, n_prev;
    logic              r_prev_v, n_prev_v;
    logic [15:0]       r_ip_ck, n_ip_ck;
    logic [15:0]       r_icmp_ck, n_icmp_ck;
    logic [6:0]        r_idx, n_idx;
    logic [7:0]        r_hi, n_hi;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_word, n_out_word;
    logic              r_out_end, n_out_end;

    logic              in_acc;
    logic              ram_we;
    logic              ram_re;
    logic [HDR_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [HDR_AW-1:0] count_after;
    logic              frame_ok;
    t_csum_ctl         csum_ctl;
    logic [15:0]       csum_sum;
    logic              sum_skip;
    t_src              src;
    logic [7:0]        emit_byte;
    logic              out_free;
    logic [6:0]        last_idx;

    assign in_acc      = i_in_valid && (r_state == ST_CAP);
    assign ram_we      = in_acc && (r_byte_count < HDR_FULL);
    assign count_after = r_byte_count + {5'd0, ram_we};
    assign frame_ok    = (count_after == HDR_FULL);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign last_idx    = r_is_arp ? ARP_LAST_BYTE : ICMP_LAST_BYTE;
    assign src         = src_map(r_is_arp, r_idx);

    assign ram_re    = (r_state == ST_SUM && r_addr <= ICMP_LAST) || (r_state == ST_EMIT_RD);
    assign ram_raddr = (r_state == ST_SUM) ? r_addr : src.addr;

    aie_ram #(
        .WIDTH (8),
        .DEPTH (HDR_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_byte_count),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // old checksum field and the ICMP type/code/checksum add nothing
    assign sum_skip = (r_prev == 6'd24) || (r_prev == 6'd25) || (r_prev == 6'd34) ||
                      (r_prev == 6'd35) || (r_prev == 6'd36) || (r_prev == 6'd37);

    always_comb begin
        csum_ctl.add   = (r_state == ST_SUM) && r_prev_v;
        csum_ctl.clr   = (in_acc && i_frame_end) || (csum_ctl.add && r_prev == IP_LAST);
        csum_ctl.value = '0;
        if (!sum_skip) begin
            csum_ctl.value = r_prev[0] ? {8'h00, ram_rdata} : {ram_rdata, 8'h00};
        end
    end

    aie_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (csum_ctl),
        .o_sum   (csum_sum)
    );

    always_comb begin
        case (src.kind)
            SRC_RAM: emit_byte = ram_rdata;
            SRC_ADJ: emit_byte = ram_rdata + r_mac_offset;
            SRC_IPH: emit_byte = r_ip_ck[15:8];
            SRC_IPL: emit_byte = r_ip_ck[7:0];
            SRC_ICH: emit_byte = r_icmp_ck[15:8];
            SRC_ICL: emit_byte = r_icmp_ck[7:0];
            default: emit_byte = src.cval;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_etype      = r_etype;
        n_is_arp     = r_is_arp;
        n_addr       = r_addr;
        n_prev       = r_prev;
        n_prev_v     = r_prev_v;
        n_ip_ck      = r_ip_ck;
        n_icmp_ck    = r_icmp_ck;
        n_idx        = r_idx;
        n_hi         = r_hi;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        n_out_end    = r_out_end;

        unique case (r_state)
            ST_CAP: begin
                if (in_acc) begin
                    n_byte_count = count_after;
                    if (ram_we && r_byte_count == TYPE_HI) begin
                        n_etype[15:8] = i_data_byte;
                    end
                    if (ram_we && r_byte_count == TYPE_LO) begin
                        n_etype[7:0] = i_data_byte;
                    end
                    if (i_frame_end) begin
                        n_byte_count = '0;
                        n_idx        = '0;
                        n_addr       = IP_FIRST;
                        n_prev_v     = 1'b0;
                        if (frame_ok && r_etype == ETH_ARP) begin
                            n_is_arp = 1'b1;
                            n_state  = ST_EMIT_RD;
                        end else if (frame_ok && r_etype == ETH_IPV4) begin
                            n_is_arp = 1'b0;
                            n_state  = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM: begin
                n_prev   = r_addr;
                n_prev_v = (r_addr <= ICMP_LAST);
                if (r_addr <= ICMP_LAST) begin
                    n_addr = r_addr + 6'd1;
                end
                if (csum_ctl.add && r_prev == IP_LAST) begin
                    n_ip_ck = ~csum_sum;
                end
                if (csum_ctl.add && r_prev == ICMP_LAST) begin
                    n_icmp_ck = ~csum_sum;
                    n_state   = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (!r_idx[0]) begin
                    n_hi    = emit_byte;
                    n_idx   = r_idx + 7'd1;
                    n_state = ST_EMIT_RD;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = {r_hi, emit_byte};
                    n_out_end   = (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        n_state = ST_CAP;
                    end else begin
                        n_idx   = r_idx + 7'd1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_CAP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CAP;
            r_byte_count <= '0;
            r_mac_offset <= 8'd2;
            r_prev_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_prev_v     <= n_prev_v;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_mac_offset <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_etype    <= n_etype;
        r_is_arp   <= n_is_arp;
        r_addr     <= n_addr;
        r_prev     <= n_prev;
        r_ip_ck    <= n_ip_ck;
        r_icmp_ck  <= n_icmp_ck;
        r_idx      <= n_idx;
        r_hi       <= n_hi;
        r_out_word <= n_out_word;
        r_out_end  <= n_out_end;
    end

    assign o_in_stall   = (r_state != ST_CAP);
    assign o_out_valid  = r_out_valid;
    assign o_reply_word = r_out_word;
    assign o_reply_end  = r_out_end;

    a_no_beat_while_sum: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |=> !$rose(r_out_valid)
    ) else $error("reply beat appeared during checksum pass");

    a_count_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_frame_end && r_byte_count < HDR_FULL)
            |=> (r_byte_count == $past(r_byte_count) + 6'd1)
    ) else $error("header byte count did not advance");

    a_sum_to_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && r_prev_v && r_prev == ICMP_LAST) |=> (r_state == ST_EMIT_RD)
    ) else $error("checksum pass did not hand over to reply build");

    a_last_beat_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_WR && n_state == ST_CAP) |=> (r_out_valid && r_out_end)
    ) else $error("reply finished without an end beat");

endmodule
